[src/uart_rx_tx_ring_buffers_defines.svh]
// assertion macros for the uart ring buffer block
`ifndef UART_RX_TX_RING_BUFFERS_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UARTRB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uart ring buffer assertion failed");

// consequent must hold in the cycle after the antecedent
`define UARTRB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uart ring buffer assertion failed");

`endif

[src/uartrb_pkg.sv]
// shared types and constants for the uart ring buffer block
package uartrb_pkg;

   localparam int RX_CAPACITY_DEF = 127;
   localparam int TX_CAPACITY_DEF = 127;
   localparam int DATA_W          = 8;
   localparam int OP_W            = 3;
   localparam int STAT_W          = 7;
   localparam int STAT_EXT_W      = 9;

   typedef enum logic [OP_W-1:0] {
      OP_LINE_RX    = 3'd0,
      OP_HOST_READ  = 3'd1,
      OP_HOST_WRITE = 3'd2,
      OP_TX_EMPTY   = 3'd3,
      OP_RX_FLUSH   = 3'd4
   } op_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_stat_type;

endpackage

[src/uartrb_if.sv]
// request and response channel interfaces
interface uartrb_req_if
   import uartrb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DATA_W-1:0] byte_in;

   modport source (output valid, output operation, output byte_in, input ready);
   modport sink   (input valid, input operation, input byte_in, output ready);
endinterface

interface uartrb_rsp_if
   import uartrb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              read_valid;
   logic              write_accepted;
   logic              rx_dropped;
   logic [DATA_W-1:0] send_data;
   logic              send_valid;
   logic              tx_irq_enabled;
   logic [STAT_W-1:0] rx_free;
   logic [STAT_W-1:0] rx_used;

   modport source (output valid, output read_data, output read_valid,
                   output write_accepted, output rx_dropped, output send_data,
                   output send_valid, output tx_irq_enabled, output rx_free,
                   output rx_used, input ready);
   modport sink   (input valid, input read_data, input read_valid,
                   input write_accepted, input rx_dropped, input send_data,
                   input send_valid, input tx_irq_enabled, input rx_free,
                   input rx_used, output ready);
endinterface

[src/uart_rx_tx_ring_buffers.sv]
// uart receive and transmit ring buffers, top level
// the response is registered: it is valid in the cycle after the request is accepted;
// the store read for a host read or transmitter-empty request happens on that edge
// one request per cycle while the response slot is free or being drained; each store has a single read port
// reset clears both rings' pointers, the transmit interrupt enable and the response slot;
// the byte stores are not cleared and need no clearing pass
module uart_rx_tx_ring_buffers
   import uartrb_pkg::*;
#(
   parameter int RX_CAPACITY = RX_CAPACITY_DEF,
   parameter int TX_CAPACITY = TX_CAPACITY_DEF
) (
   input  logic          clock,
   input  logic          reset,
   uartrb_req_if.sink    req_chan,
   uartrb_rsp_if.source  rsp_chan
);

`include "uart_rx_tx_ring_buffers_defines.svh"

   localparam int RX_PTR_W = $clog2(RX_CAPACITY + 1);
   localparam int TX_PTR_W = $clog2(TX_CAPACITY + 1);

   ring_cmd_type        rx_cmd, tx_cmd;
   ring_stat_type       rx_stat, tx_stat;
   logic [DATA_W-1:0]   rx_rdata, tx_rdata;
   logic [RX_PTR_W-1:0] rx_count;
   logic [TX_PTR_W-1:0] tx_count;

   logic                    req_fire;
   logic                    rsp_valid_ff;
   logic                    read_valid_ff, read_valid_in;
   logic                    write_ok_ff, write_ok_in;
   logic                    dropped_ff, dropped_in;
   logic                    send_valid_ff, send_valid_in;
   logic                    tx_irq_ff, tx_irq_in;
   logic [STAT_EXT_W-1:0]   used_ext;
   logic [STAT_EXT_W-1:0]   free_ext;

   // a new request may enter whenever the response slot is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // operation decode into ring commands and response flags
   always_comb begin
      rx_cmd        = '0;
      tx_cmd        = '0;
      read_valid_in = 1'b0;
      write_ok_in   = 1'b0;
      dropped_in    = 1'b0;
      send_valid_in = 1'b0;
      tx_irq_in     = tx_irq_ff;
      unique case (op_type'(req_chan.operation))
         OP_LINE_RX: begin
            rx_cmd.push = !rx_stat.full;
            dropped_in  = rx_stat.full;
         end
         OP_HOST_READ: begin
            rx_cmd.pop    = !rx_stat.empty;
            read_valid_in = !rx_stat.empty;
         end
         OP_HOST_WRITE: begin
            tx_cmd.push = !tx_stat.full;
            write_ok_in = !tx_stat.full;
            tx_irq_in   = 1'b1;
         end
         OP_TX_EMPTY: begin
            tx_cmd.pop    = !tx_stat.empty;
            send_valid_in = !tx_stat.empty;
            tx_irq_in     = !tx_stat.empty && tx_irq_ff;
         end
         OP_RX_FLUSH: begin
            rx_cmd.flush = 1'b1;
         end
         default: begin
         end
      endcase
      if (!req_fire) begin
         rx_cmd    = '0;
         tx_cmd    = '0;
         tx_irq_in = tx_irq_ff;
      end
   end

   uartrb_ring #(.CAPACITY(RX_CAPACITY)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .wdata (req_chan.byte_in),
      .rdata (rx_rdata),
      .stat  (rx_stat),
      .count (rx_count)
   );

   uartrb_ring #(.CAPACITY(TX_CAPACITY)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .wdata (req_chan.byte_in),
      .rdata (tx_rdata),
      .stat  (tx_stat),
      .count (tx_count)
   );

   // response slot and interrupt enable
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         read_valid_ff <= 1'b0;
         write_ok_ff   <= 1'b0;
         dropped_ff    <= 1'b0;
         send_valid_ff <= 1'b0;
         tx_irq_ff     <= 1'b0;
      end else begin
         tx_irq_ff <= tx_irq_in;
         if (req_fire) begin
            rsp_valid_ff  <= 1'b1;
            read_valid_ff <= read_valid_in;
            write_ok_ff   <= write_ok_in;
            dropped_ff    <= dropped_in;
            send_valid_ff <= send_valid_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // receive status from the live pointers, which only move on acceptance
   assign used_ext = STAT_EXT_W'(rx_count);
   assign free_ext = STAT_EXT_W'(RX_CAPACITY) - used_ext;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_data      = read_valid_ff ? rx_rdata : '0;
   assign rsp_chan.read_valid     = read_valid_ff;
   assign rsp_chan.write_accepted = write_ok_ff;
   assign rsp_chan.rx_dropped     = dropped_ff;
   assign rsp_chan.send_data      = send_valid_ff ? tx_rdata : '0;
   assign rsp_chan.send_valid     = send_valid_ff;
   assign rsp_chan.tx_irq_enabled = tx_irq_ff;
   assign rsp_chan.rx_free        = free_ext[STAT_W-1:0];
   assign rsp_chan.rx_used        = used_ext[STAT_W-1:0];

   // checks
   `UARTRB_ASSERT_NOW(a_rx_count_bound, 1'b1, used_ext <= STAT_EXT_W'(RX_CAPACITY))
   `UARTRB_ASSERT_NOW(a_drop_only_when_full, rsp_valid_ff && dropped_ff, rx_stat.full)
   `UARTRB_ASSERT_NEXT(a_write_sets_irq,
      req_fire && (req_chan.operation == OP_HOST_WRITE), tx_irq_ff && rsp_valid_ff)

endmodule

[src/uartrb_ring.sv]
// one byte ring: synchronous store plus head and tail pointers
module uartrb_ring
   import uartrb_pkg::*;
#(
   parameter int CAPACITY = RX_CAPACITY_DEF,
   localparam int RING    = CAPACITY + 1,
   localparam int PTR_W   = $clog2(RING)
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_cmd_type      cmd,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata,
   output ring_stat_type     stat,
   output logic [PTR_W-1:0]  count
);

   logic [DATA_W-1:0] mem [RING];
   logic [DATA_W-1:0] rdata_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [PTR_W-1:0]  head_next;
   logic [PTR_W-1:0]  tail_next;
   logic [PTR_W:0]    diff;

   // pointer advance with wrap at the ring size
   assign head_next = (head_ff == PTR_W'(RING - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_next = (tail_ff == PTR_W'(RING - 1)) ? '0 : tail_ff + PTR_W'(1);

   assign stat.full  = (head_next == tail_ff);
   assign stat.empty = (head_ff == tail_ff);

   // fill level, wrap case corrected by the ring size
   always_comb begin
      diff = {1'b0, head_ff} - {1'b0, tail_ff};
      if (head_ff < tail_ff) begin
         diff = diff + (PTR_W+1)'(RING);
      end
   end
   assign count = diff[PTR_W-1:0];

   // pointer updates, push and pop are gated by the caller
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (cmd.push) begin
         head_in = head_next;
      end
      if (cmd.pop) begin
         tail_in = tail_next;
      end
      if (cmd.flush) begin
         tail_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[head_ff] <= wdata;
      end
      if (cmd.pop) begin
         rdata_ff <= mem[tail_ff];
      end
   end

   assign rdata = rdata_ff;

endmodule

[tb/uart_rx_tx_ring_buffers_tb.sv]
// self-checking testbench for the uart receive and transmit ring buffers
module uart_rx_tx_ring_buffers_tb;
   import uartrb_pkg::*;

   localparam int RX_SLOTS      = RX_CAPACITY_DEF + 1;
   localparam int TX_SLOTS      = TX_CAPACITY_DEF + 1;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int LONG_HOLD     = 200;
   localparam int DRAIN_CYCLES  = 4;
   localparam int PACE_WINDOW   = 32;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              read_valid;
      logic              write_accepted;
      logic              rx_dropped;
      logic [DATA_W-1:0] send_data;
      logic              send_valid;
      logic              tx_irq_enabled;
      logic [STAT_W-1:0] rx_free;
      logic [STAT_W-1:0] rx_used;
   } ring_status_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] data;
      int                reps;
      bit                typed;
      ring_status_type   want;
   } stim_row_type;

   typedef enum int {
      MIX_BURST, RX_FILL_BURST, RX_DRAIN_BURST, TX_FILL_BURST, TX_DRAIN_BURST, NOISE_BURST
   } burst_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   uartrb_req_if req_chan ();
   uartrb_rsp_if rsp_chan ();

   uart_rx_tx_ring_buffers uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // mirror of the two rings
   logic [DATA_W-1:0] rx_bytes [RX_SLOTS];
   logic [DATA_W-1:0] tx_bytes [TX_SLOTS];
   int   rx_head = 0;
   int   rx_tail = 0;
   int   tx_head = 0;
   int   tx_tail = 0;
   logic tx_irq  = 1'b0;

   ring_status_type awaited_status [$];
   stim_row_type    stimulus_rows [$];
   int mismatch_count = 0;
   int response_index = 0;
   bit send_pace      = 1'b1;
   bit recv_pace      = 1'b1;
   bit hold_request   = 1'b0;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int ring_step(input int ptr, input int slots);
      return (ptr + 1 >= slots) ? 0 : ptr + 1;
   endfunction

   // next ring state and the status the block should report for it
   function automatic ring_status_type apply_ring_request(input logic [OP_W-1:0] op,
                                                          input logic [DATA_W-1:0] data);
      ring_status_type s;
      int used;
      s = '0;
      case (op)
         OP_LINE_RX: begin
            if (ring_step(rx_head, RX_SLOTS) != rx_tail) begin
               rx_bytes[rx_head] = data;
               rx_head = ring_step(rx_head, RX_SLOTS);
            end else begin
               s.rx_dropped = 1'b1;
            end
         end
         OP_HOST_READ: begin
            if (rx_head != rx_tail) begin
               s.read_data  = rx_bytes[rx_tail];
               s.read_valid = 1'b1;
               rx_tail = ring_step(rx_tail, RX_SLOTS);
            end
         end
         OP_HOST_WRITE: begin
            if (ring_step(tx_head, TX_SLOTS) != tx_tail) begin
               tx_bytes[tx_head] = data;
               tx_head = ring_step(tx_head, TX_SLOTS);
               s.write_accepted = 1'b1;
            end
            // a refused write still enables the interrupt so the ring drains
            tx_irq = 1'b1;
         end
         OP_TX_EMPTY: begin
            if (tx_tail != tx_head) begin
               s.send_data  = tx_bytes[tx_tail];
               s.send_valid = 1'b1;
               tx_tail = ring_step(tx_tail, TX_SLOTS);
            end else begin
               tx_irq = 1'b0;
            end
         end
         OP_RX_FLUSH: rx_tail = rx_head;
         default: ;
      endcase
      // count wraps through the ring size when head is below tail
      used = (rx_head >= rx_tail) ? rx_head - rx_tail : RX_SLOTS - (rx_tail - rx_head);
      s.tx_irq_enabled = tx_irq;
      s.rx_free        = STAT_W'(RX_CAPACITY_DEF - used);
      s.rx_used        = STAT_W'(used);
      return s;
   endfunction

   function automatic ring_status_type make_status(
      input logic [DATA_W-1:0] rd_data, input logic rd_ok, input logic wr_ok,
      input logic drop, input logic [DATA_W-1:0] snd_data, input logic snd_ok,
      input logic irq, input logic [STAT_W-1:0] free_n, input logic [STAT_W-1:0] used_n);
      ring_status_type s;
      s.read_data      = rd_data;
      s.read_valid     = rd_ok;
      s.write_accepted = wr_ok;
      s.rx_dropped     = drop;
      s.send_data      = snd_data;
      s.send_valid     = snd_ok;
      s.tx_irq_enabled = irq;
      s.rx_free        = free_n;
      s.rx_used        = used_n;
      return s;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                          input int reps, input bit typed, input ring_status_type want);
      stim_row_type row;
      row.op    = op;
      row.data  = data;
      row.reps  = reps;
      row.typed = typed;
      row.want  = want;
      stimulus_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("MISMATCH response %0d %s: got 0x%0h expected 0x%0h",
               response_index, field, got, want);
      mismatch_count++;
   endtask

   // compare one accepted response with the oldest pending status
   task automatic check_response();
      ring_status_type want;
      response_index++;
      if (awaited_status.size() == 0) begin
         report_mismatch("unexpected response", 8'h00, 8'h00);
         return;
      end
      want = awaited_status.pop_front();
      if (rsp_chan.read_data !== want.read_data)
         report_mismatch("read_data", rsp_chan.read_data, want.read_data);
      if (rsp_chan.read_valid !== want.read_valid)
         report_mismatch("read_valid", rsp_chan.read_valid, want.read_valid);
      if (rsp_chan.write_accepted !== want.write_accepted)
         report_mismatch("write_accepted", rsp_chan.write_accepted, want.write_accepted);
      if (rsp_chan.rx_dropped !== want.rx_dropped)
         report_mismatch("rx_dropped", rsp_chan.rx_dropped, want.rx_dropped);
      if (rsp_chan.send_data !== want.send_data)
         report_mismatch("send_data", rsp_chan.send_data, want.send_data);
      if (rsp_chan.send_valid !== want.send_valid)
         report_mismatch("send_valid", rsp_chan.send_valid, want.send_valid);
      if (rsp_chan.tx_irq_enabled !== want.tx_irq_enabled)
         report_mismatch("tx_irq_enabled", rsp_chan.tx_irq_enabled, want.tx_irq_enabled);
      if (rsp_chan.rx_free !== want.rx_free)
         report_mismatch("rx_free", rsp_chan.rx_free, want.rx_free);
      if (rsp_chan.rx_used !== want.rx_used)
         report_mismatch("rx_used", rsp_chan.rx_used, want.rx_used);
   endtask

   // offer one request; entered and left just after a falling edge
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                               input bit typed, input ring_status_type want);
      ring_status_type predicted;
      int gap;
      gap = send_pace ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.byte_in   <= data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = apply_ring_request(op, data);
      awaited_status.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // stop offering until every pending status has come back
   task automatic wait_all_delivered();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (awaited_status.size() != 0);
   endtask

   // response side: random stalls, occasional long hold, checking
   initial begin
      int stall;
      int window;
      rsp_chan.ready = 1'b0;
      window = 0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end
         if (window == 0) begin
            recv_pace = ($urandom_range(0, 2) != 0);
            window = PACE_WINDOW;
         end
         window--;
         stall = recv_pace ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         check_response();
         @(negedge clock);
      end
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // stimulus
   initial begin
      ring_status_type idle_status;
      logic [OP_W-1:0] op;
      burst_kind_type kind;
      int burst_len;
      int burst_index;
      int random_count;

      req_chan.valid     = 1'b0;
      req_chan.operation = OP_LINE_RX;
      req_chan.byte_in   = '0;
      burst_index  = 0;
      random_count = 0;
      idle_status  = make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 7'd127, 7'd0);

      // empty rings answer with status only
      add_row(OP_HOST_READ,  8'h00, 1, 1'b1, idle_status);
      add_row(OP_TX_EMPTY,   8'h00, 1, 1'b1, idle_status);
      add_row(OP_RX_FLUSH,   8'h00, 1, 1'b1, idle_status);
      add_row(OP_RSVD_FIRST, 8'hFF, 1, 1'b1, idle_status);
      add_row(OP_RSVD_LAST,  8'hFF, 1, 1'b1, idle_status);
      // byte extremes through the receive ring
      add_row(OP_LINE_RX,   8'h00, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 7'd126, 7'd1));
      add_row(OP_LINE_RX,   8'hFF, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 7'd125, 7'd2));
      add_row(OP_HOST_READ, 8'h00, 1, 1'b1,
              make_status(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 7'd126, 7'd1));
      add_row(OP_HOST_READ, 8'h00, 1, 1'b1,
              make_status(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 7'd127, 7'd0));
      // byte extremes through the transmit ring
      add_row(OP_HOST_WRITE, 8'hFF, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 7'd127, 7'd0));
      add_row(OP_HOST_WRITE, 8'h00, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 7'd127, 7'd0));
      add_row(OP_TX_EMPTY,   8'h00, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 7'd127, 7'd0));
      add_row(OP_TX_EMPTY,   8'h00, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 7'd127, 7'd0));
      // nothing left to send clears the enable
      add_row(OP_TX_EMPTY,   8'h00, 1, 1'b1, idle_status);
      // fill the receive ring, then overflow drops the byte
      add_row(OP_LINE_RX, 8'h11, RX_CAPACITY_DEF, 1'b0, idle_status);
      add_row(OP_LINE_RX, 8'hEE, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 7'd127));
      add_row(OP_RSVD_FIRST, 8'h5A, 1, 1'b0, idle_status);
      // pop a few and refill so head wraps below tail
      add_row(OP_HOST_READ, 8'h00, 3, 1'b0, idle_status);
      add_row(OP_LINE_RX,   8'h40, 2, 1'b0, idle_status);
      add_row(OP_HOST_READ, 8'h00, 1, 1'b0, idle_status);
      add_row(OP_RX_FLUSH,  8'h00, 1, 1'b1, idle_status);
      // fill the transmit ring, a refused write keeps the enable set
      add_row(OP_HOST_WRITE, 8'h80, TX_CAPACITY_DEF, 1'b0, idle_status);
      add_row(OP_HOST_WRITE, 8'h7F, 1, 1'b1,
              make_status(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 7'd127, 7'd0));
      add_row(OP_TX_EMPTY,   8'h00, TX_CAPACITY_DEF, 1'b0, idle_status);
      add_row(OP_TX_EMPTY,   8'h00, 1, 1'b1, idle_status);

      // reset
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (stimulus_rows[i]) begin
         for (int k = 0; k < stimulus_rows[i].reps; k++) begin
            send_request(stimulus_rows[i].op, DATA_W'(stimulus_rows[i].data + k),
                         stimulus_rows[i].typed, stimulus_rows[i].want);
         end
      end
      wait_all_delivered();

      // random bursts: mostly fill and drain runs with random bytes, some noise
      while (random_count < RANDOM_ITEMS) begin
         burst_index++;
         send_pace = ($urandom_range(0, 3) != 0);
         if (burst_index % 9 == 0)
            wait_all_delivered();
         if (burst_index % 25 == 3) begin
            // long response hold while requests keep coming
            hold_request = 1'b1;
            send_pace = 1'b0;
            kind = RX_FILL_BURST;
         end else begin
            kind = burst_kind_type'($urandom_range(MIX_BURST, NOISE_BURST));
         end
         case (kind)
            MIX_BURST:   burst_len = $urandom_range(10, 60);
            NOISE_BURST: burst_len = $urandom_range(1, 4);
            default:     burst_len = $urandom_range(20, 140);
         endcase
         for (int k = 0; k < burst_len; k++) begin
            case (kind)
               RX_FILL_BURST:  op = OP_LINE_RX;
               RX_DRAIN_BURST: op = OP_HOST_READ;
               TX_FILL_BURST:  op = OP_HOST_WRITE;
               TX_DRAIN_BURST: op = OP_TX_EMPTY;
               MIX_BURST:      op = OP_W'($urandom_range(OP_LINE_RX, OP_RX_FLUSH));
               default: begin
                  op = ($urandom_range(0, 3) == 0) ? OP_RX_FLUSH
                       : OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
               end
            endcase
            send_request(op, DATA_W'($urandom_range(0, 255)), 1'b0, idle_status);
            if (op <= OP_RX_FLUSH)
               random_count++;
         end
      end

      // drain and let the pipeline settle
      req_chan.valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/uartrb_pkg.sv
src/uartrb_if.sv
src/uartrb_ring.sv
src/uart_rx_tx_ring_buffers.sv
tb/uart_rx_tx_ring_buffers_tb.sv
